@@ rtl/dla_pkg.sv @@
`default_nettype none

package dla_pkg;

  localparam int MAX_POINTS      = 256;
  localparam int COORD_FRAC_BITS = 14;

  localparam int COORD_W = 16;
  localparam int VEL_W   = 18;
  localparam int SUM_W   = 19;
  localparam int DIFF_W  = 17;
  localparam int ADDR_W  = $clog2(MAX_POINTS);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int PNT_W   = 3 * COORD_W;

  localparam int STEP_W  = 15;
  localparam int RANGE_W = 15;
  localparam int SUBS_W  = 4;

  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  localparam logic [1:0] REG_STEP_LENGTH = 2'd0;
  localparam logic [1:0] REG_STICK_RANGE = 2'd1;
  localparam logic [1:0] REG_SUBSTEPS    = 2'd2;

  localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(164);
  localparam logic [RANGE_W-1:0] RANGE_RST = RANGE_W'(1229);
  localparam logic [SUBS_W-1:0]  SUBS_RST  = SUBS_W'(5);

  localparam logic signed [SUM_W-1:0]  ONE_S    = SUM_W'(1 << COORD_FRAC_BITS);
  localparam logic signed [DIFF_W-1:0] ONE_D    = DIFF_W'(1 << COORD_FRAC_BITS);
  localparam logic signed [31:0]       ROUND_C  = 32'(1 << (COORD_FRAC_BITS - 1));
  localparam logic [CNT_W-1:0]         MAX_CNT  = CNT_W'(MAX_POINTS);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [VEL_W-1:0]   vel_t;

endpackage

`default_nettype wire

@@ rtl/dla_particle_walk_step.sv @@
`default_nettype none

// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_pos_x/y/z, in_dir_x/y/z
// out_      output     out_valid/out_stall out_new_x/y/z, out_stuck, out_stuck_count,
//                                          out_edge_reached, out_store_full
// cfg       APB        psel/penable/pready paddr, pwrite, pwdata, prdata
//
// One walk at a time. The single point memory read port visits one stored point per
// cycle, in each substep run and once more for the wall scan.
// The wall scan is skipped once the edge flag is set.
// Synchronous active-low reset; entry 0 of the point memory reads as the origin.
// A finished result waits in the output register under out_stall while a new
// transaction is already taken.

module dla_particle_walk_step
  import dla_pkg::*;
(
  input  wire                  clk,
  input  wire                  rst_n,

  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire  [COORD_W-1:0]   in_pos_x,
  input  wire  [COORD_W-1:0]   in_pos_y,
  input  wire  [COORD_W-1:0]   in_pos_z,
  input  wire  [COORD_W-1:0]   in_dir_x,
  input  wire  [COORD_W-1:0]   in_dir_y,
  input  wire  [COORD_W-1:0]   in_dir_z,

  output logic                 out_valid,
  input  wire                  out_stall,
  output logic [COORD_W-1:0]   out_new_x,
  output logic [COORD_W-1:0]   out_new_y,
  output logic [COORD_W-1:0]   out_new_z,
  output logic                 out_stuck,
  output logic [CNT_W-1:0]     out_stuck_count,
  output logic                 out_edge_reached,
  output logic                 out_store_full,

  input  wire                  psel,
  input  wire                  penable,
  input  wire                  pwrite,
  input  wire  [CFG_AW-1:0]    paddr,
  input  wire  [CFG_DW-1:0]    pwdata,
  output logic [CFG_DW-1:0]    prdata,
  output logic                 pready
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_MOVE  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_STICK = 3'd4;
  localparam logic [2:0] S_EDGE  = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [STEP_W-1:0]  step_length_r;
  logic [RANGE_W-1:0] stick_range_r;
  logic [SUBS_W-1:0]  substeps_r;

  logic [2:0]          state_r, state_nxt;
  coord_t              pos_r [3];
  coord_t              pos_nxt [3];
  coord_t              dir_r [3];
  coord_t              dir_nxt [3];
  vel_t                vel_r [3];
  vel_t                vel_nxt [3];
  logic [2*RANGE_W-1:0] r2_r, r2_nxt;
  logic [SUBS_W-1:0]   sub_r, sub_nxt;
  logic [CNT_W-1:0]    issue_r, issue_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                edge_r, edge_nxt;
  logic                stuck_r, stuck_nxt;
  logic                full_r, full_nxt;

  logic                out_valid_r, out_valid_nxt;
  coord_t              out_pos_r [3];
  coord_t              out_pos_nxt [3];
  logic                out_stuck_r, out_stuck_nxt;
  logic [CNT_W-1:0]    out_count_r, out_count_nxt;
  logic                out_edge_r, out_edge_nxt;
  logic                out_full_r, out_full_nxt;

  logic [PNT_W-1:0]    mem [MAX_POINTS];
  logic [PNT_W-1:0]    mem_q_r;
  logic                q_zero_r;
  logic                q_vld_r, q_vld_nxt;
  logic [31:0]         sq_r [3];
  logic                sq_vld_r, sq_vld_nxt;

  logic                rd_en;
  logic                wr_en;
  logic                hit;
  logic                edge_hit;
  logic                pipe_empty;
  logic [SUBS_W-1:0]   sub_inc;
  logic [31:0]         dist2;
  coord_t              pt_c [3];
  logic signed [DIFF_W-1:0] lim_hi;
  logic signed [DIFF_W-1:0] lim_lo;
  logic [2:0]          edge_ax;
  coord_t              in_pos [3];
  coord_t              in_dir [3];
  logic                cfg_wr;

  function automatic coord_t wrap_axis(input coord_t p, input vel_t v);
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(p) + SUM_W'(v);
    if (s < -ONE_S) begin
      s = ONE_S;
    end else if (s > ONE_S) begin
      s = -ONE_S;
    end
    return s[COORD_W-1:0];
  endfunction

  function automatic vel_t scale_dir(input coord_t d, input logic [STEP_W-1:0] step);
    logic signed [31:0] prod;
    prod = 32'(d) * 32'($signed({1'b0, step}));
    prod = prod + ROUND_C;
    return prod[31:COORD_FRAC_BITS];
  endfunction

  function automatic logic [31:0] sq_dist(input coord_t p, input coord_t c);
    logic signed [DIFF_W-1:0] d;
    logic [COORD_W-1:0]       ad;
    d  = DIFF_W'(p) - DIFF_W'(c);
    ad = d[DIFF_W-1] ? COORD_W'(-d) : d[COORD_W-1:0];
    return 32'(ad) * 32'(ad);
  endfunction

  // Configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_length_r <= STEP_RST;
      stick_range_r <= RANGE_RST;
      substeps_r    <= SUBS_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_STEP_LENGTH: step_length_r <= pwdata[STEP_W-1:0];
        REG_STICK_RANGE: stick_range_r <= pwdata[RANGE_W-1:0];
        REG_SUBSTEPS:    substeps_r    <= pwdata[SUBS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_STEP_LENGTH: prdata = CFG_DW'(step_length_r);
      REG_STICK_RANGE: prdata = CFG_DW'(stick_range_r);
      REG_SUBSTEPS:    prdata = CFG_DW'(substeps_r);
      default:         prdata = '0;
    endcase
  end

  // Point memory
  assign in_pos[0] = in_pos_x;
  assign in_pos[1] = in_pos_y;
  assign in_pos[2] = in_pos_z;
  assign in_dir[0] = in_dir_x;
  assign in_dir[1] = in_dir_y;
  assign in_dir[2] = in_dir_z;

  assign hit   = sq_vld_r && (state_r == S_SCAN) && (dist2 <= 32'(r2_r));
  assign rd_en = (((state_r == S_SCAN) && !hit) || (state_r == S_EDGE)) &&
                 (issue_r != count_r);
  assign wr_en = (state_r == S_STICK) && (count_r != MAX_CNT);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count_r[ADDR_W-1:0]] <= {pos_r[2], pos_r[1], pos_r[0]};
    end
    if (rd_en) begin
      mem_q_r  <= mem[issue_r[ADDR_W-1:0]];
      q_zero_r <= (issue_r[ADDR_W-1:0] == '0);
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pt_c[a] = q_zero_r ? '0 : mem_q_r[a*COORD_W +: COORD_W];
    end
  end

  // Distance and wall tests
  always_ff @(posedge clk) begin
    for (int a = 0; a < 3; a++) begin
      sq_r[a] <= sq_dist(pos_r[a], pt_c[a]);
    end
  end

  assign dist2  = sq_r[0] + sq_r[1] + sq_r[2];
  assign lim_hi = ONE_D - $signed({2'b00, stick_range_r});
  assign lim_lo = $signed({2'b00, stick_range_r}) - ONE_D;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      edge_ax[a] = (DIFF_W'(pt_c[a]) > lim_hi) || (DIFF_W'(pt_c[a]) < lim_lo);
    end
  end

  assign edge_hit   = q_vld_r && (|edge_ax);
  assign pipe_empty = (issue_r == count_r) && !q_vld_r && !sq_vld_r;
  assign sub_inc    = sub_r + SUBS_W'(1);
  assign q_vld_nxt  = rd_en;
  assign sq_vld_nxt = q_vld_r && (state_r == S_SCAN) && !hit;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    dir_nxt       = dir_r;
    vel_nxt       = vel_r;
    r2_nxt        = r2_r;
    sub_nxt       = sub_r;
    issue_nxt     = issue_r;
    count_nxt     = count_r;
    edge_nxt      = edge_r;
    stuck_nxt     = stuck_r;
    full_nxt      = full_r;
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_stuck_nxt = out_stuck_r;
    out_count_nxt = out_count_r;
    out_edge_nxt  = out_edge_r;
    out_full_nxt  = out_full_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pos_nxt   = in_pos;
          dir_nxt   = in_dir;
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        for (int a = 0; a < 3; a++) begin
          vel_nxt[a] = scale_dir(dir_r[a], step_length_r);
        end
        r2_nxt    = (2*RANGE_W)'(stick_range_r) * (2*RANGE_W)'(stick_range_r);
        sub_nxt   = '0;
        stuck_nxt = 1'b0;
        full_nxt  = 1'b0;
        issue_nxt = '0;
        if (substeps_r == '0) begin
          state_nxt = edge_r ? S_DONE : S_EDGE;
        end else begin
          state_nxt = S_MOVE;
        end
      end
      S_MOVE: begin
        for (int a = 0; a < 3; a++) begin
          pos_nxt[a] = wrap_axis(pos_r[a], vel_r[a]);
        end
        issue_nxt = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (hit) begin
          state_nxt = S_STICK;
        end else if (rd_en) begin
          issue_nxt = issue_r + CNT_W'(1);
        end else if (pipe_empty) begin
          issue_nxt = '0;
          if (sub_inc == substeps_r) begin
            state_nxt = edge_r ? S_DONE : S_EDGE;
          end else begin
            sub_nxt   = sub_inc;
            state_nxt = S_MOVE;
          end
        end
      end
      S_STICK: begin
        stuck_nxt = 1'b1;
        if (wr_en) begin
          count_nxt = count_r + CNT_W'(1);
        end else begin
          full_nxt = 1'b1;
        end
        issue_nxt = '0;
        state_nxt = edge_r ? S_DONE : S_EDGE;
      end
      S_EDGE: begin
        if (rd_en) begin
          issue_nxt = issue_r + CNT_W'(1);
        end
        if (edge_hit) begin
          edge_nxt = 1'b1;
        end
        if ((issue_r == count_r) && !q_vld_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_r;
          out_stuck_nxt = stuck_r;
          out_count_nxt = count_r;
          out_edge_nxt  = edge_r;
          out_full_nxt  = full_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(1);
      edge_r      <= 1'b0;
      out_valid_r <= 1'b0;
      q_vld_r     <= 1'b0;
      sq_vld_r    <= 1'b0;
      issue_r     <= '0;
      sub_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      edge_r      <= edge_nxt;
      out_valid_r <= out_valid_nxt;
      q_vld_r     <= q_vld_nxt;
      sq_vld_r    <= sq_vld_nxt;
      issue_r     <= issue_nxt;
      sub_r       <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    dir_r       <= dir_nxt;
    vel_r       <= vel_nxt;
    r2_r        <= r2_nxt;
    stuck_r     <= stuck_nxt;
    full_r      <= full_nxt;
    out_pos_r   <= out_pos_nxt;
    out_stuck_r <= out_stuck_nxt;
    out_count_r <= out_count_nxt;
    out_edge_r  <= out_edge_nxt;
    out_full_r  <= out_full_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_new_x        = out_pos_r[0];
  assign out_new_y        = out_pos_r[1];
  assign out_new_z        = out_pos_r[2];
  assign out_stuck        = out_stuck_r;
  assign out_stuck_count  = out_count_r;
  assign out_edge_reached = out_edge_r;
  assign out_store_full   = out_full_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) && (count_r <= MAX_CNT))
    else $error("point count out of range");

  a_stick_append: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_STICK) && (count_r != MAX_CNT) |=>
      (count_r == $past(count_r) + CNT_W'(1)))
    else $error("stuck point not appended");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside of completion");

  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> (!q_vld_r && !sq_vld_r))
    else $error("scan pipeline busy while idle");

endmodule

`default_nettype wire

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dla_pkg::*;

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int ITEMS = 460;
  localparam int HOLD_CYCLES = 600;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t dir_x;
    coord_t dir_y;
    coord_t dir_z;
  } walk_t;

  typedef struct {
    coord_t           new_x;
    coord_t           new_y;
    coord_t           new_z;
    logic             stuck;
    logic [CNT_W-1:0] stuck_count;
    logic             at_edge;
    logic             full;
  } landing_t;

  class walk_scoreboard;
    int step_len;
    int range;
    int nsub;
    int pts[MAX_POINTS][3];
    int npts;
    bit edge_seen;
    int errors;
    landing_t expected_landings[$];

    function new();
      step_len = STEP_RST;
      range = RANGE_RST;
      nsub = SUBS_RST;
      npts = 1;
      edge_seen = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_STEP_LENGTH: step_len = val[STEP_W-1:0];
        REG_STICK_RANGE: range = val[RANGE_W-1:0];
        REG_SUBSTEPS: nsub = val[SUBS_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [1:0] idx);
      case (idx)
        REG_STEP_LENGTH: return step_len;
        REG_STICK_RANGE: return range;
        REG_SUBSTEPS: return nsub;
        default: return '0;
      endcase
    endfunction

    function bit touches_cluster(longint p[3]);
      longint d;
      longint d2;
      for (int i = 0; i < npts; i++) begin
        d2 = 0;
        for (int a = 0; a < 3; a++) begin
          d = p[a] - pts[i][a];
          d2 += d * d;
        end
        if (d2 <= longint'(range) * range) return 1;
      end
      return 0;
    endfunction

    function void note_walk(walk_t w);
      longint p[3];
      longint v[3];
      longint one;
      coord_t dir[3];
      bit hit;
      bit full;
      landing_t r;
      one = longint'(1) << COORD_FRAC_BITS;
      p[0] = w.pos_x;
      p[1] = w.pos_y;
      p[2] = w.pos_z;
      dir[0] = w.dir_x;
      dir[1] = w.dir_y;
      dir[2] = w.dir_z;
      for (int a = 0; a < 3; a++)
        v[a] = (longint'(dir[a]) * step_len + (one >>> 1)) >>> COORD_FRAC_BITS;
      hit = 0;
      full = 0;
      for (int s = 0; s < nsub && !hit; s++) begin
        for (int a = 0; a < 3; a++) begin
          p[a] = p[a] + v[a];
          if (p[a] < -one) p[a] = one;
          if (p[a] > one) p[a] = -one;
        end
        if (touches_cluster(p)) begin
          hit = 1;
          if (npts < MAX_POINTS) begin
            for (int a = 0; a < 3; a++) pts[npts][a] = int'(p[a]);
            npts++;
          end else begin
            full = 1;
          end
        end
      end
      for (int i = 0; i < npts; i++)
        for (int a = 0; a < 3; a++)
          if (pts[i][a] > one - range || pts[i][a] < range - one) edge_seen = 1;
      r.new_x = coord_t'(p[0]);
      r.new_y = coord_t'(p[1]);
      r.new_z = coord_t'(p[2]);
      r.stuck = hit;
      r.stuck_count = CNT_W'(npts);
      r.at_edge = edge_seen;
      r.full = full;
      expected_landings.insert(expected_landings.size(), r);
    endfunction

    function void match_field(string name, logic signed [31:0] want,
                              logic signed [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_walk(landing_t got);
      landing_t want;
      if (expected_landings.size() == 0) begin
        $error("result with no walk pending: new_x %0d new_y %0d new_z %0d",
               got.new_x, got.new_y, got.new_z);
        errors++;
        return;
      end
      want = expected_landings.pop_front();
      match_field("new_x", want.new_x, got.new_x);
      match_field("new_y", want.new_y, got.new_y);
      match_field("new_z", want.new_z, got.new_z);
      match_field("stuck", want.stuck, got.stuck);
      match_field("stuck_count", want.stuck_count, got.stuck_count);
      match_field("edge_reached", want.at_edge, got.at_edge);
      match_field("store_full", want.full, got.full);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [COORD_W-1:0] in_pos_x = '0;
  logic [COORD_W-1:0] in_pos_y = '0;
  logic [COORD_W-1:0] in_pos_z = '0;
  logic [COORD_W-1:0] in_dir_x = '0;
  logic [COORD_W-1:0] in_dir_y = '0;
  logic [COORD_W-1:0] in_dir_z = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [COORD_W-1:0] out_new_x;
  logic [COORD_W-1:0] out_new_y;
  logic [COORD_W-1:0] out_new_z;
  logic               out_stuck;
  logic [CNT_W-1:0]   out_stuck_count;
  logic               out_edge_reached;
  logic               out_store_full;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  walk_scoreboard sb;
  bit quiet = 0;
  bit hold_req = 0;
  int items_sent = 0;
  int idle_cycles = 0;

  dla_particle_walk_step u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    walk_t w;
    landing_t l;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        w.pos_x = in_pos_x;
        w.pos_y = in_pos_y;
        w.pos_z = in_pos_z;
        w.dir_x = in_dir_x;
        w.dir_y = in_dir_y;
        w.dir_z = in_dir_z;
        sb.note_walk(w);
      end
      if (out_valid && !out_stall) begin
        l.new_x = out_new_x;
        l.new_y = out_new_y;
        l.new_z = out_new_z;
        l.stuck = out_stuck;
        l.stuck_count = out_stuck_count;
        l.at_edge = out_edge_reached;
        l.full = out_store_full;
        sb.check_walk(l);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // result-side backpressure
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 0;
        out_stall <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic int sym(int a);
    return int'($urandom_range(2 * a, 0)) - a;
  endfunction

  task automatic drive_walk(int px, int py, int pz, int dx, int dy, int dz);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pos_x <= COORD_W'(px);
    in_pos_y <= COORD_W'(py);
    in_pos_z <= COORD_W'(pz);
    in_dir_x <= COORD_W'(dx);
    in_dir_y <= COORD_W'(dy);
    in_dir_z <= COORD_W'(dz);
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // near_pct: start close to a stored point; raw_pct: unconstrained 16-bit fields
  task automatic send_random(int reach, int near_pct, int raw_pct);
    int pick;
    int k;
    int c[3];
    int d[3];
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, sb.npts - 1);
    for (int a = 0; a < 3; a++) begin
      d[a] = sym(16384);
      if (pick < near_pct) begin
        c[a] = sb.pts[k][a] + sym(sb.range + 200);
      end else if (pick >= 100 - raw_pct) begin
        c[a] = $urandom_range(0, 65535);
        d[a] = $urandom_range(0, 65535);
      end else begin
        c[a] = sym(reach);
      end
    end
    drive_walk(c[0], c[1], c[2], d[0], d[1], d[2]);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.expected_landings.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    logic [31:0] want;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, val);
    if (idx != REG_SPARE) begin
      pwrite <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
      want = sb.reg_value(idx);
      if (prdata !== want) begin
        $error("register %0d readback: expected %0d, got %0d", idx, want, prdata);
        sb.errors++;
      end
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int k;
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    drive_walk(0, 0, 0, 16384, 0, 0);
    drive_walk(16384, 16384, 16384, 16384, 16384, 16384);
    drive_walk(-16384, -16384, -16384, -16384, -16384, -16384);
    drive_walk(32767, -32768, 0, 0, 0, 0);
    drive_walk(16384, -16384, 0, 0, 0, 0);
    drive_walk(16385, -16385, 100, 0, 0, 0);
    drive_walk(8000, -8000, 0, 32767, -32768, 1);
    drive_walk(-1, -1, -1, -1, -1, -1);
    drive_walk(1000, 0, 0, -16384, 0, 0);
    drive_walk(16000, 0, 0, 16384, 16384, 0);
    drive_walk(0, 5000, -5000, 0, -16384, 16384);
    drive_walk(-32768, 32767, -32768, -32768, 32767, -32768);

    // stall the result side long enough to back up the input
    hold_req = 1;
    repeat (60) send_random(4000, 60, 10);

    drain();
    cfg_write(REG_STEP_LENGTH, 0);
    cfg_write(REG_STICK_RANGE, 0);
    cfg_write(REG_SUBSTEPS, 2);
    repeat (8) begin
      k = $urandom_range(0, sb.npts - 1);
      drive_walk(sb.pts[k][0], sb.pts[k][1], sb.pts[k][2], sym(16384), sym(16384),
                 sym(16384));
    end
    repeat (7) send_random(16384, 50, 20);

    // half-step ties round toward plus infinity
    drain();
    cfg_write(REG_STEP_LENGTH, 8192);
    cfg_write(REG_STICK_RANGE, 300);
    cfg_write(REG_SUBSTEPS, 1);
    drive_walk(0, 0, 0, -1, 1, -3);
    drive_walk(100, -100, 5, 3, -5, 7);
    drive_walk(-8000, 8000, 0, -32767, 32767, -7);
    repeat (10) send_random(8000, 60, 10);

    drain();
    cfg_write(REG_STEP_LENGTH, 32'hFFFF_FFFF);
    cfg_write(REG_STICK_RANGE, 32'hFFFF_C001);
    cfg_write(REG_SUBSTEPS, 32'hFFFF_FFF0);
    cfg_write(REG_SPARE, 32'h1234_5678);
    repeat (10) send_random(16384, 40, 30);

    drain();
    cfg_write(REG_STEP_LENGTH, 16384);
    cfg_write(REG_STICK_RANGE, 16384);
    cfg_write(REG_SUBSTEPS, 15);
    repeat (20) send_random(16384, 30, 20);

    // fill the point store, then keep sticking against a full store
    drain();
    cfg_write(REG_STEP_LENGTH, 164);
    cfg_write(REG_SUBSTEPS, 3);
    repeat (285) send_random(8192, 0, 0);

    while (items_sent < ITEMS) begin
      drain();
      cfg_write(REG_STEP_LENGTH, $urandom_range(1, 2000));
      cfg_write(REG_STICK_RANGE, $urandom_range(600, 3000));
      cfg_write(REG_SUBSTEPS, $urandom_range(1, 5));
      quiet = (items_sent >= ITEMS - 60);
      repeat (20) send_random(16384, 60, 10);
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ dla_particle_walk_step.f @@
rtl/dla_pkg.sv
rtl/dla_particle_walk_step.sv
tb/tb.sv
